>>> design/ttr_pkg.sv
// Shared constants and register codes for the tensor transpose index remapper.
package ttr_pkg;

   localparam int IDX_W      = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int EXT_W      = 16;
   localparam int NUM_EXT    = 4;
   localparam int DIMS_W     = 3;
   localparam int PERM_W     = 8;
   localparam int STRIDE_W   = 48;
   localparam int SUM_W      = 64;

   localparam logic [PERM_W-1:0] PERM_RESET = 8'd228;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_NUM_DIMS         = 3'd0,
      REG_EXTENT_0         = 3'd1,
      REG_EXTENT_1         = 3'd2,
      REG_EXTENT_2         = 3'd3,
      REG_EXTENT_3         = 3'd4,
      REG_AXIS_PERMUTATION = 3'd5,
      REG_SOURCE_CONSTANT  = 3'd6
   } csr_reg_type;

endpackage

>>> design/ttr_if.sv
// Valid/ready channel interfaces for requests, responses and register writes.
interface ttr_req_if;
   import ttr_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] dest_index;
   logic             run_end;
   modport source(output valid, dest_index, run_end, input ready);
   modport sink(input valid, dest_index, run_end, output ready);
endinterface

interface ttr_rsp_if;
   import ttr_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] source_index;
   logic             run_end_out;
   modport source(output valid, source_index, run_end_out, input ready);
   modport sink(input valid, source_index, run_end_out, output ready);
endinterface

interface ttr_csr_if;
   import ttr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> design/ttr_cfg.sv
// Configuration registers and the derived divisors, source strides and element count.
module ttr_cfg #(
   parameter int ND = 4,
   parameter int NL = 3
) (
   input  logic                                         clock,
   input  logic                                         reset,
   ttr_csr_if.sink                                      csr_ch,
   output logic [NL-1:0][ttr_pkg::EXT_W-1:0]            div_ff,
   output logic [NL-1:0][ttr_pkg::STRIDE_W-1:0]         lw_ff,
   output logic [ttr_pkg::STRIDE_W-1:0]                 qw_ff,
   output logic [ttr_pkg::SUM_W-1:0]                    total_ff,
   output logic                                         const_ff
);
   import ttr_pkg::*;

   logic [DIMS_W-1:0]                num_dims_ff;
   logic [NUM_EXT-1:0][EXT_W-1:0]    extent_ff;
   logic [PERM_W-1:0]                perm_ff;

   logic [DIMS_W-1:0]                n_eff;
   logic [NUM_EXT-1:0][EXT_W-1:0]    eext;
   logic [NUM_EXT-1:0][EXT_W-1:0]    sext_in;
   logic [NL-1:0][EXT_W-1:0]         div_in;

   logic [DIMS_W-1:0]                n_ff;
   logic [NUM_EXT-1:0][EXT_W-1:0]    sext_ff;
   logic [2*EXT_W-1:0]               s1_ff;
   logic [EXT_W-1:0]                 s2_ff;
   logic [EXT_W-1:0]                 e0_d2_ff;
   logic [EXT_W-1:0]                 e1_d2_ff;
   logic [STRIDE_W-1:0]              s0_ff;
   logic [2*EXT_W-1:0]               s1_d3_ff;
   logic [EXT_W-1:0]                 s2_d3_ff;
   logic [EXT_W-1:0]                 e0_d3_ff;
   logic [NUM_EXT-1:0][STRIDE_W-1:0] str_ff;
   logic [NL-1:0][STRIDE_W-1:0]      lw_in;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= DIMS_W'(1);
         extent_ff   <= {NUM_EXT{EXT_W'(1)}};
         perm_ff     <= PERM_RESET;
         const_ff    <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.index))
            REG_NUM_DIMS:         num_dims_ff  <= csr_ch.data[DIMS_W-1:0];
            REG_EXTENT_0:         extent_ff[0] <= csr_ch.data;
            REG_EXTENT_1:         extent_ff[1] <= csr_ch.data;
            REG_EXTENT_2:         extent_ff[2] <= csr_ch.data;
            REG_EXTENT_3:         extent_ff[3] <= csr_ch.data;
            REG_AXIS_PERMUTATION: perm_ff      <= csr_ch.data[PERM_W-1:0];
            REG_SOURCE_CONSTANT:  const_ff     <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // Source extents follow the permutation; a later destination axis wins a collision.
   always_comb begin
      logic [DIMS_W-1:0] j;
      n_eff = num_dims_ff;
      if (n_eff == '0) begin
         n_eff = DIMS_W'(1);
      end else if (n_eff > DIMS_W'(ND)) begin
         n_eff = DIMS_W'(ND);
      end
      for (int d = 0; d < NUM_EXT; d++) begin
         eext[d]    = (extent_ff[d] == '0) ? EXT_W'(1) : extent_ff[d];
         sext_in[d] = EXT_W'(1);
      end
      for (int d = 0; d < NUM_EXT; d++) begin
         if (DIMS_W'(d) < n_eff && DIMS_W'(perm_ff[2*d +: 2]) < n_eff) begin
            sext_in[perm_ff[2*d +: 2]] = eext[d];
         end
      end
      // Level k of the divider peels off destination axis n-1-k, innermost first.
      for (int k = 0; k < NL; k++) begin
         j = n_eff - DIMS_W'(1) - DIMS_W'(k);
         if ((DIMS_W'(k) + DIMS_W'(1)) < n_eff) begin
            div_in[k] = eext[j[1:0]];
         end else begin
            div_in[k] = EXT_W'(1);
         end
      end
   end

   always_comb begin
      logic [DIMS_W-1:0] j;
      logic [PERM_W-1:0] sh;
      for (int k = 0; k < NL; k++) begin
         j  = n_ff - DIMS_W'(1) - DIMS_W'(k);
         sh = perm_ff >> {j[1:0], 1'b0};
         if ((DIMS_W'(k) + DIMS_W'(1)) < n_ff) begin
            lw_in[k] = str_ff[sh[1:0]];
         end else begin
            lw_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_eff;
      sext_ff  <= sext_in;
      div_ff   <= div_in;
      s1_ff    <= sext_ff[2] * sext_ff[3];
      s2_ff    <= sext_ff[3];
      e0_d2_ff <= sext_ff[0];
      e1_d2_ff <= sext_ff[1];
      s0_ff    <= s1_ff * e1_d2_ff;
      s1_d3_ff <= s1_ff;
      s2_d3_ff <= s2_ff;
      e0_d3_ff <= e0_d2_ff;
      total_ff <= s0_ff * e0_d3_ff;
      str_ff[0] <= s0_ff;
      str_ff[1] <= STRIDE_W'(s1_d3_ff);
      str_ff[2] <= STRIDE_W'(s2_d3_ff);
      str_ff[3] <= STRIDE_W'(1);
      qw_ff    <= str_ff[perm_ff[1:0]];
      lw_ff    <= lw_in;
   end

endmodule

>>> design/ttr_div_level.sv
// One pipelined restoring divider level: splits one coordinate off by a 16-bit extent.
module ttr_div_level #(
   parameter int IW = 32,
   parameter int NL = 3,
   parameter int K  = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic [ttr_pkg::EXT_W-1:0]         divisor,
   input  logic                              in_valid,
   input  logic                              in_run,
   input  logic [IW-1:0]                     in_x,
   input  logic [NL-1:0][ttr_pkg::EXT_W-1:0] in_rems,
   output logic                              out_valid,
   output logic                              out_run,
   output logic [IW-1:0]                     out_x,
   output logic [NL-1:0][ttr_pkg::EXT_W-1:0] out_rems
);
   import ttr_pkg::*;

   logic [IW-1:0]                     valid_ff;
   logic [IW-1:0]                     run_ff;
   logic [IW-1:0][IW-1:0]             x_ff;
   logic [IW-1:0][EXT_W-1:0]          rem_ff;
   logic [IW-1:0][NL-1:0][EXT_W-1:0]  rems_ff;
   logic [IW-1:0][IW-1:0]             x_in;
   logic [IW-1:0][EXT_W-1:0]          rem_in;

   // One quotient bit per stage; the dividend shifts out as the quotient shifts in.
   for (genvar s = 0; s < IW; s++) begin : g_step
      logic                     pvalid;
      logic                     prun;
      logic [IW-1:0]            px;
      logic [EXT_W-1:0]         prem;
      logic [NL-1:0][EXT_W-1:0] prems;
      logic [EXT_W:0]           shifted;
      logic                     ge;

      if (s == 0) begin : g_first
         assign pvalid = in_valid;
         assign prun   = in_run;
         assign px     = in_x;
         assign prem   = '0;
         assign prems  = in_rems;
      end else begin : g_next
         assign pvalid = valid_ff[s-1];
         assign prun   = run_ff[s-1];
         assign px     = x_ff[s-1];
         assign prem   = rem_ff[s-1];
         assign prems  = rems_ff[s-1];
      end

      assign shifted   = {prem, px[IW-1]};
      assign ge        = shifted >= {1'b0, divisor};
      assign rem_in[s] = ge ? EXT_W'(shifted - {1'b0, divisor}) : shifted[EXT_W-1:0];
      assign x_in[s]   = {px[IW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= pvalid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            run_ff[s]  <= prun;
            x_ff[s]    <= x_in[s];
            rem_ff[s]  <= rem_in[s];
            rems_ff[s] <= prems;
         end
      end
   end

   assign out_valid = valid_ff[IW-1];
   assign out_run   = run_ff[IW-1];
   assign out_x     = x_ff[IW-1];

   always_comb begin
      out_rems    = rems_ff[IW-1];
      out_rems[K] = rem_ff[IW-1];
   end

endmodule

>>> design/ttr_mac.sv
// Three-stage weighting of the coordinates by their source strides and summation.
module ttr_mac #(
   parameter int IW = 32,
   parameter int NL = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  logic                                 in_run,
   input  logic [IW-1:0]                        in_q,
   input  logic [NL-1:0][ttr_pkg::EXT_W-1:0]    in_rems,
   input  logic [NL-1:0][ttr_pkg::STRIDE_W-1:0] lw,
   input  logic [ttr_pkg::STRIDE_W-1:0]         qw,
   output logic                                 out_valid,
   output logic                                 out_run,
   output logic [ttr_pkg::SUM_W-1:0]            out_sum
);
   import ttr_pkg::*;

   logic [2:0]                valid_ff;
   logic [2:0]                run_ff;
   logic [IW+31:0]            qlo_ff;
   logic [IW+15:0]            qhi_ff;
   logic [NL-1:0][SUM_W-1:0]  prod_ff;
   logic [SUM_W-1:0]          qsum_ff;
   logic [SUM_W-1:0]          psum_ff;
   logic [SUM_W-1:0]          sum_ff;
   logic [SUM_W-1:0]          psum_in;

   // The outer coordinate is up to IW bits wide, so its 48-bit stride is split in two.
   always_comb begin
      psum_in = '0;
      for (int k = 0; k < NL; k++) begin
         psum_in = psum_in + prod_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         run_ff  <= {run_ff[1:0], in_run};
         qlo_ff  <= in_q * qw[31:0];
         qhi_ff  <= in_q * qw[STRIDE_W-1:32];
         for (int k = 0; k < NL; k++) begin
            prod_ff[k] <= in_rems[k] * lw[k];
         end
         qsum_ff <= SUM_W'(qlo_ff) + SUM_W'({qhi_ff, 32'd0});
         psum_ff <= psum_in;
         sum_ff  <= qsum_ff + psum_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_run   = run_ff[2];
   assign out_sum   = sum_ff;

endmodule

>>> design/ttr_mod.sv
// Pipelined 64-bit remainder by the source element count, one dividend bit per stage.
module ttr_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic [ttr_pkg::SUM_W-1:0] total,
   input  logic                      in_valid,
   input  logic                      in_run,
   input  logic [ttr_pkg::SUM_W-1:0] in_sum,
   output logic                      out_valid,
   output logic                      out_run,
   output logic [ttr_pkg::SUM_W-1:0] out_rem
);
   import ttr_pkg::*;

   logic [SUM_W-1:0]            valid_ff;
   logic [SUM_W-1:0]            run_ff;
   logic [SUM_W-1:0][SUM_W-1:0] x_ff;
   logic [SUM_W-1:0][SUM_W-1:0] rem_ff;

   for (genvar s = 0; s < SUM_W; s++) begin : g_step
      logic             pvalid;
      logic             prun;
      logic [SUM_W-1:0] px;
      logic [SUM_W-1:0] prem;
      logic [SUM_W:0]   shifted;
      logic             ge;
      logic [SUM_W-1:0] rem_in;

      if (s == 0) begin : g_first
         assign pvalid = in_valid;
         assign prun   = in_run;
         assign px     = in_sum;
         assign prem   = '0;
      end else begin : g_next
         assign pvalid = valid_ff[s-1];
         assign prun   = run_ff[s-1];
         assign px     = x_ff[s-1];
         assign prem   = rem_ff[s-1];
      end

      // The partial remainder stays below the count, so the shifted value fits 65 bits.
      assign shifted = {prem, px[SUM_W-1]};
      assign ge      = shifted >= {1'b0, total};
      assign rem_in  = ge ? SUM_W'(shifted - {1'b0, total}) : shifted[SUM_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= pvalid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            run_ff[s] <= prun;
            x_ff[s]   <= {px[SUM_W-2:0], 1'b0};
            rem_ff[s] <= rem_in;
         end
      end
   end

   assign out_valid = valid_ff[SUM_W-1];
   assign out_run   = run_ff[SUM_W-1];
   assign out_rem   = rem_ff[SUM_W-1];

endmodule

>>> design/tensor_transpose_index_remap_top.sv
// Top level of the tensor transpose source index generator.
// Takes one destination index word per clock while the pipeline advances and returns one
// source index word per word, in order. MAX_DIMS is capped at four and INDEX_WIDTH at 32
// (with a single dimension the divider levels are replaced by four delay stages). Each
// word passes the entry register, the bit-serial divider levels that split off each
// coordinate, the weighting by source strides, the 64-stage remainder by the source
// element count and the output register. All stages advance together; the pipeline
// holds while the output word waits and the response side is not ready. Derived
// strides settle through a chain of registers after a register write.
module tensor_transpose_index_remap_top #(
   parameter int MAX_DIMS    = 4,
   parameter int INDEX_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   ttr_req_if.sink  req_ch,
   ttr_rsp_if.source rsp_ch,
   ttr_csr_if.sink  csr_ch
);
   import ttr_pkg::*;

   localparam int ND  = (MAX_DIMS < NUM_EXT) ? MAX_DIMS : NUM_EXT;
   localparam int IW  = (INDEX_WIDTH < IDX_W) ? INDEX_WIDTH : IDX_W;
   localparam int NL  = (ND > 1) ? ND - 1 : 1;
   localparam int PAD = 4;

   logic                          adv;
   logic [NL-1:0][EXT_W-1:0]      div;
   logic [NL-1:0][STRIDE_W-1:0]   lw;
   logic [STRIDE_W-1:0]           qw;
   logic [SUM_W-1:0]              total;
   logic                          src_const;

   logic                          entry_valid_ff;
   logic                          entry_run_ff;
   logic [IW-1:0]                 entry_x_ff;

   logic                          ch_valid [ND];
   logic                          ch_run   [ND];
   logic [IW-1:0]                 ch_x     [ND];
   logic [NL-1:0][EXT_W-1:0]      ch_rems  [ND];

   logic                          m_valid;
   logic                          m_run;
   logic [IW-1:0]                 m_q;
   logic [NL-1:0][EXT_W-1:0]      m_rems;

   logic                          s_valid;
   logic                          s_run;
   logic [SUM_W-1:0]              s_sum;

   logic                          r_valid;
   logic                          r_run;
   logic [SUM_W-1:0]              r_rem;

   logic                          out_valid_ff;
   logic                          out_run_ff;
   logic [IDX_W-1:0]              out_idx_ff;

   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   ttr_cfg #(.ND(ND), .NL(NL)) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_ch   (csr_ch),
      .div_ff   (div),
      .lw_ff    (lw),
      .qw_ff    (qw),
      .total_ff (total),
      .const_ff (src_const)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (adv) begin
         entry_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         entry_run_ff <= req_ch.run_end;
         entry_x_ff   <= req_ch.dest_index[IW-1:0];
      end
   end

   assign ch_valid[0] = entry_valid_ff;
   assign ch_run[0]   = entry_run_ff;
   assign ch_x[0]     = entry_x_ff;
   assign ch_rems[0]  = '0;

   for (genvar k = 0; k < ND - 1; k++) begin : g_level
      ttr_div_level #(.IW(IW), .NL(NL), .K(k)) u_level (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .divisor   (div[k]),
         .in_valid  (ch_valid[k]),
         .in_run    (ch_run[k]),
         .in_x      (ch_x[k]),
         .in_rems   (ch_rems[k]),
         .out_valid (ch_valid[k+1]),
         .out_run   (ch_run[k+1]),
         .out_x     (ch_x[k+1]),
         .out_rems  (ch_rems[k+1])
      );
   end

   if (ND == 1) begin : g_pad
      // Gives the stride registers time to settle after a write.
      logic [PAD-1:0]          pvalid_ff;
      logic [PAD-1:0]          prun_ff;
      logic [PAD-1:0][IW-1:0]  px_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            pvalid_ff <= '0;
         end else if (adv) begin
            pvalid_ff <= {pvalid_ff[PAD-2:0], ch_valid[0]};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            prun_ff <= {prun_ff[PAD-2:0], ch_run[0]};
            px_ff   <= {px_ff[PAD-2:0], ch_x[0]};
         end
      end

      assign m_valid = pvalid_ff[PAD-1];
      assign m_run   = prun_ff[PAD-1];
      assign m_q     = px_ff[PAD-1];
      assign m_rems  = '0;
   end else begin : g_nopad
      assign m_valid = ch_valid[ND-1];
      assign m_run   = ch_run[ND-1];
      assign m_q     = ch_x[ND-1];
      assign m_rems  = ch_rems[ND-1];
   end

   ttr_mac #(.IW(IW), .NL(NL)) u_mac (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m_valid),
      .in_run    (m_run),
      .in_q      (m_q),
      .in_rems   (m_rems),
      .lw        (lw),
      .qw        (qw),
      .out_valid (s_valid),
      .out_run   (s_run),
      .out_sum   (s_sum)
   );

   ttr_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .total     (total),
      .in_valid  (s_valid),
      .in_run    (s_run),
      .in_sum    (s_sum),
      .out_valid (r_valid),
      .out_run   (r_run),
      .out_rem   (r_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= r_valid;
      end
   end

   // A broadcast constant source always reads element zero.
   always_ff @(posedge clock) begin
      if (adv) begin
         out_run_ff <= r_run;
         out_idx_ff <= src_const ? '0 : IDX_W'(r_rem[IW-1:0]);
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.run_end_out  = out_run_ff;
   assign rsp_ch.source_index = out_idx_ff;

endmodule
